// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked implication
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/cpg_pkg.sv =====
// Package: types, constants and tables of the circle point generator
`timescale 1ns / 1ps
package cpg_pkg;

   localparam int MAX_POINTS   = 64;
   localparam int CORDIC_STEPS = 16;
   localparam int DIV_STEPS    = 33;
   localparam int ITER_W       = 6;
   localparam int ATAN_IW      = 5;
   localparam int XY_W         = 20;
   localparam int PROD_W       = 31;

   localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;
   localparam logic [31:0] START_PHASE = 32'hC000_0000;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN_INV = 20'sd39797;
   localparam logic [6:0] MAX_COUNT = 7'(MAX_POINTS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PINIT,
      ST_ROT,
      ST_MUL,
      ST_RND,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              load;
      logic              div_step;
      logic              div_first;
      logic              cordic_init;
      logic              cordic_step;
      logic [ATAN_IW-1:0] iter;
      logic              mul;
      logic              rnd;
      logic              advance;
   } cmd_type;

   typedef struct packed {
      logic req_zero;
      logic last;
   } status_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [31:0] atan_turns(input logic [ATAN_IW-1:0] i);
      logic [31:0] v;
      unique case (i)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/cpg_req_if.sv =====
// Request channel interface
`timescale 1ns / 1ps
interface cpg_req_if;
   logic              valid;
   logic              ready;
   logic signed [11:0] center_x;
   logic signed [11:0] center_y;
   logic [9:0]        radius;
   logic [6:0]        point_count;

   modport source (output valid, center_x, center_y, radius, point_count, input ready);
   modport sink   (input valid, center_x, center_y, radius, point_count, output ready);
endinterface

// ===== rtl/cpg_rsp_if.sv =====
// Result channel interface
`timescale 1ns / 1ps
interface cpg_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [12:0] point_x;
   logic signed [12:0] point_y;
   logic [5:0]        point_index;
   logic              last;

   modport source (output valid, point_x, point_y, point_index, last, input ready);
   modport sink   (input valid, point_x, point_y, point_index, last, output ready);
endinterface

// ===== rtl/cpg_datapath.sv =====
// Datapath: step divider, CORDIC, scaling and rounding
`timescale 1ns / 1ps
module cpg_datapath import cpg_pkg::*; (
   input  logic               clock,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic signed [11:0] in_center_x,
   input  logic signed [11:0] in_center_y,
   input  logic [9:0]         in_radius,
   input  logic [6:0]         in_point_count,
   output logic signed [12:0] point_x,
   output logic signed [12:0] point_y,
   output logic [5:0]         point_index,
   output logic               last
);

   logic signed [11:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [9:0]  r_ff, r_in;
   logic [6:0]  count_ff, count_in;
   logic [6:0]  rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] phase_ff, phase_in;
   logic [5:0]  index_ff, index_in;
   logic [1:0]  quad_ff, quad_in;
   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0] z_ff, z_in;
   logic signed [PROD_W-1:0] pc_ff, pc_in, ps_ff, ps_in;
   logic signed [12:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [5:0]  oidx_ff, oidx_in;
   logic        olast_ff, olast_in;

   logic [6:0]  rem_sh;
   logic [31:0] phase_sum;
   logic signed [XY_W-1:0] dx, dy, c_sel, s_sel;

   function automatic logic signed [12:0] round_add(input logic signed [PROD_W-1:0] p,
                                                    input logic signed [11:0] ctr);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] sum;
      logic signed [15:0] val;
      logic signed [15:0] tot;
      mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      sum = mag + PROD_W'(32768);
      val = $signed({1'b0, sum[PROD_W-1:16]});
      if (p[PROD_W-1]) begin
         val = -val;
      end
      tot = val + 16'(ctr);
      return tot[12:0];
   endfunction

   assign rem_sh    = {rem_ff[5:0], cmd.div_first};
   assign phase_sum = phase_ff + EIGHTH_TURN;
   assign dx        = y_ff >>> cmd.iter;
   assign dy        = x_ff >>> cmd.iter;

   always_comb begin
      unique case (quad_ff)
         2'd0: begin c_sel = x_ff;  s_sel = y_ff;  end
         2'd1: begin c_sel = -y_ff; s_sel = x_ff;  end
         2'd2: begin c_sel = -x_ff; s_sel = -y_ff; end
         default: begin c_sel = y_ff; s_sel = -x_ff; end
      endcase
   end

   always_comb begin
      cx_in = cx_ff; cy_in = cy_ff; r_in = r_ff; count_in = count_ff;
      rem_in = rem_ff; quo_in = quo_ff; phase_in = phase_ff; index_in = index_ff;
      quad_in = quad_ff; x_in = x_ff; y_in = y_ff; z_in = z_ff;
      pc_in = pc_ff; ps_in = ps_ff;
      ox_in = ox_ff; oy_in = oy_ff; oidx_in = oidx_ff; olast_in = olast_ff;

      if (cmd.load) begin
         cx_in    = in_center_x;
         cy_in    = in_center_y;
         r_in     = in_radius;
         count_in = (in_point_count > MAX_COUNT) ? MAX_COUNT : in_point_count;
         rem_in   = '0;
         quo_in   = '0;
         phase_in = START_PHASE;
         index_in = '0;
      end
      // restoring divide of 2^32 by the count, one quotient bit a beat
      if (cmd.div_step) begin
         if (rem_sh >= count_ff) begin
            rem_in = rem_sh - count_ff;
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[30:0], 1'b0};
         end
      end
      if (cmd.cordic_init) begin
         quad_in = phase_sum[31:30];
         z_in    = $signed(phase_ff - {phase_sum[31:30], 30'b0});
         x_in    = CORDIC_GAIN_INV;
         y_in    = '0;
      end
      if (cmd.cordic_step) begin
         if (!z_ff[31]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - $signed(atan_turns(cmd.iter));
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + $signed(atan_turns(cmd.iter));
         end
      end
      if (cmd.mul) begin
         pc_in = $signed({1'b0, r_ff}) * c_sel;
         ps_in = $signed({1'b0, r_ff}) * s_sel;
      end
      if (cmd.rnd) begin
         ox_in    = round_add(pc_ff, cx_ff);
         oy_in    = round_add(ps_ff, cy_ff);
         oidx_in  = index_ff;
         olast_in = ({1'b0, index_ff} + 7'd1) == count_ff;
      end
      if (cmd.advance) begin
         phase_in = phase_ff + quo_ff;
         index_in = index_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in; cy_ff <= cy_in; r_ff <= r_in; count_ff <= count_in;
      rem_ff <= rem_in; quo_ff <= quo_in; phase_ff <= phase_in; index_ff <= index_in;
      quad_ff <= quad_in; x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      pc_ff <= pc_in; ps_ff <= ps_in;
      ox_ff <= ox_in; oy_ff <= oy_in; oidx_ff <= oidx_in; olast_ff <= olast_in;
   end

   assign status.req_zero = (in_point_count == 7'd0);
   assign status.last     = olast_ff;
   assign point_x         = ox_ff;
   assign point_y         = oy_ff;
   assign point_index     = oidx_ff;
   assign last            = olast_ff;

endmodule

// ===== rtl/cpg_ctrl.sv =====
// Controller: sequences division, CORDIC passes and result beats
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cpg_ctrl import cpg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      iter_in       = iter_ff;
      cmd           = '0;
      cmd.iter      = iter_ff[ATAN_IW-1:0];
      cmd.div_first = (iter_ff == '0);
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // drop a request with no points
            if (req_valid && !status.req_zero) begin
               cmd.load = 1'b1;
               iter_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(DIV_STEPS - 1)) begin
               state_in = ST_PINIT;
            end
         end
         ST_PINIT: begin
            cmd.cordic_init = 1'b1;
            iter_in         = '0;
            state_in        = ST_ROT;
         end
         ST_ROT: begin
            cmd.cordic_step = 1'b1;
            iter_in         = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_RND;
         end
         ST_RND: begin
            cmd.rnd  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_PINIT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `ASSERT_CLK(a_no_overlap, clock, reset, !(req_ready && rsp_valid), "ready while beat pending")
   `ASSERT_IMPL(a_div_end, clock, reset, (state_ff == ST_DIV) && (iter_ff == ITER_W'(DIV_STEPS - 1)), state_ff == ST_PINIT, "divide did not finish")
   `ASSERT_IMPL(a_last_idle, clock, reset, rsp_valid && rsp_ready && status.last, req_ready, "not idle after last beat")

endmodule

// ===== rtl/circle_point_generator.sv =====
// Top level: evenly spaced points on a circle
// A request first runs the 33-step restoring divide for the phase step; each point then
// takes a CORDIC pass, a scaling multiply and a rounding step before its result beat.
// The CORDIC runs one iteration per cycle; a new request is taken only after the last beat.
// Reset: synchronous, active high; returns the controller to idle, ready for a request.
`timescale 1ns / 1ps
module circle_point_generator import cpg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   cpg_req_if.sink  req,
   cpg_rsp_if.source rsp
);

   cmd_type    cmd;
   status_type status;

   cpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cpg_datapath u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .in_center_x    (req.center_x),
      .in_center_y    (req.center_y),
      .in_radius      (req.radius),
      .in_point_count (req.point_count),
      .point_x        (rsp.point_x),
      .point_y        (rsp.point_y),
      .point_index    (rsp.point_index),
      .last           (rsp.last)
   );

endmodule

// ===== tb/sv/tb_circle_point_generator.sv =====
// Testbench for the circle point generator: directed and randomised requests checked against a point predictor
`timescale 1ns / 1ps
module tb_circle_point_generator;
   import cpg_pkg::*;

   typedef struct packed {
      logic signed [11:0] cx;
      logic signed [11:0] cy;
      logic [9:0]         radius;
      logic [6:0]         count;
   } circle_req_t;

   typedef struct packed {
      logic signed [12:0] px;
      logic signed [12:0] py;
      logic [5:0]         index;
      logic               last;
   } point_t;

   localparam int NUM_RANDOM = 280;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cpg_req_if req_if ();
   cpg_rsp_if rsp_if ();

   circle_point_generator DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   always #2 clock = ~clock;

   circle_req_t pending_reqs[$];
   point_t      expected_points[$];
   int          error_count = 0;
   bit          hold_sender = 1'b0;
   int          send_gap = 0;
   int          sink_gap = 0;

   // atan(2^-i) in 2^-32 turn, kept apart from the package table
   const longint arctan_tab[24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_scaled(longint r, longint q);
      longint p;
      p = r * q;
      if (p >= 0) return (p + 32768) >>> 16;
      return -((-p + 32768) >>> 16);
   endfunction

   task automatic rotate_phase(input logic [31:0] phase, output longint c, output longint s);
      logic [31:0] quad_sum, resid;
      logic [1:0]  quad;
      longint      x, y, z, dx, dy;
      quad_sum = phase + 32'h2000_0000;
      quad = quad_sum[31:30];
      resid = phase - {quad, 30'd0};
      z = longint'($signed(resid));
      x = 39797;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_tab[i];
         end else begin
            x += dx; y -= dy; z += arctan_tab[i];
         end
      end
      case (quad)
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   task automatic predict_points(input circle_req_t r);
      int          n;
      logic [31:0] step, phase;
      longint      c, s, px, py;
      point_t      p;
      n = r.count;
      if (n == 0) return;
      if (n > MAX_POINTS) n = MAX_POINTS;
      step = 32'((64'd1 << 32) / n);
      phase = 32'hC000_0000;
      for (int k = 0; k < n; k++) begin
         rotate_phase(phase, c, s);
         px = round_scaled(longint'(r.radius), c) + longint'(r.cx);
         py = round_scaled(longint'(r.radius), s) + longint'(r.cy);
         p.px = px[12:0];
         p.py = py[12:0];
         p.index = k[5:0];
         p.last = (k + 1 == n);
         expected_points.push_back(p);
         phase = phase + step;
      end
   endtask

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [6:0] pick_count();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return 7'd0;
      if (sel == 1) return 7'($urandom_range(65, 127));
      if (sel == 2) return 7'd64;
      return 7'($urandom_range(1, 12));
   endfunction

   // Driver: hold the beat until accepted, predict at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && req_if.ready) begin
         predict_points('{req_if.center_x, req_if.center_y, req_if.radius,
                          req_if.point_count});
         send_gap = pick_gap();
         if (send_gap == 0 && !hold_sender && pending_reqs.size() > 0) begin
            circle_req_t r;
            r = pending_reqs.pop_front();
            req_if.center_x <= r.cx; req_if.center_y <= r.cy;
            req_if.radius <= r.radius; req_if.point_count <= r.count;
         end else begin
            req_if.valid <= 1'b0;
         end
      end else if (!req_if.valid) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (!hold_sender && pending_reqs.size() > 0) begin
            circle_req_t r;
            r = pending_reqs.pop_front();
            req_if.valid <= 1'b1;
            req_if.center_x <= r.cx; req_if.center_y <= r.cy;
            req_if.radius <= r.radius; req_if.point_count <= r.count;
         end
      end
   end

   // Monitor: check each accepted point against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_points.size() == 0) begin
               $error("unexpected point beat x=%0d y=%0d", rsp_if.point_x, rsp_if.point_y);
               error_count++;
            end else begin
               point_t e;
               e = expected_points.pop_front();
               if (rsp_if.point_x !== e.px) begin
                  $error("point_x expected %0d got %0d", e.px, rsp_if.point_x);
                  error_count++;
               end
               if (rsp_if.point_y !== e.py) begin
                  $error("point_y expected %0d got %0d", e.py, rsp_if.point_y);
                  error_count++;
               end
               if (rsp_if.point_index !== e.index) begin
                  $error("point_index expected %0d got %0d", e.index, rsp_if.point_index);
                  error_count++;
               end
               if (rsp_if.last !== e.last) begin
                  $error("last expected %0d got %0d", e.last, rsp_if.last);
                  error_count++;
               end
            end
         end
         if (sink_gap > 0) begin
            sink_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            sink_gap = pick_gap();
            rsp_if.ready <= (sink_gap == 0);
         end
      end
   end

   initial begin
      circle_req_t r;
      req_if.valid = 1'b0;
      req_if.center_x = '0;
      req_if.center_y = '0;
      req_if.radius = '0;
      req_if.point_count = '0;
      rsp_if.ready = 1'b0;
      // directed: field extremes, zero, one, saturation, full count
      pending_reqs.push_back('{12'sh000, 12'sh000, 10'd0, 7'd1});
      pending_reqs.push_back('{12'sh7FF, 12'sh7FF, 10'd1023, 7'd4});
      pending_reqs.push_back('{12'sh800, 12'sh800, 10'd1023, 7'd8});
      pending_reqs.push_back('{12'sh7FF, 12'sh800, 10'd1023, 7'd3});
      pending_reqs.push_back('{12'sh000, 12'sh000, 10'd100, 7'd0});
      pending_reqs.push_back('{12'sh123, 12'shEDC, 10'd500, 7'd127});
      pending_reqs.push_back('{12'sh000, 12'sh000, 10'd1023, 7'd64});
      pending_reqs.push_back('{12'shFFF, 12'sh001, 10'd1, 7'd65});
      pending_reqs.push_back('{12'sh555, 12'shAAA, 10'd512, 7'd6});
      pending_reqs.push_back('{12'shAAA, 12'sh555, 10'd341, 7'd1});
      pending_reqs.push_back('{12'sh000, 12'sh000, 10'd7, 7'd5});
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // let the last popped beat reach the bus before waiting for its acceptance
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      wait (!req_if.valid);
      // pause the sender until every point has drained
      hold_sender = 1'b1;
      wait (expected_points.size() == 0);
      @(posedge clock);
      hold_sender = 1'b0;
      for (int i = 0; i < NUM_RANDOM; i++) begin
         r.cx = 12'($urandom);
         r.cy = 12'($urandom);
         r.radius = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(1000, 1023))
                                                : 10'($urandom);
         r.count = pick_count();
         pending_reqs.push_back(r);
      end
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      wait (!req_if.valid);
      wait (expected_points.size() == 0);
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
